@@ rtl/core/bcmp_pkg.sv @@
`timescale 1ns / 1ps

package bcmp_pkg;

  // Status word bit positions.
  localparam int unsigned BitOvertemp     = 12;
  localparam int unsigned BitDischarging  = 6;
  localparam int unsigned BitFull         = 5;
  localparam logic [15:0] StatusAllOnes   = 16'hffff;

  // State reset values and counter ceiling.
  localparam logic [15:0] SocReset        = 16'd50;
  localparam logic [3:0]  CountMax        = 4'd15;

  // LED pattern codes.
  localparam logic [2:0] LedSteadyErr     = 3'd0;
  localparam logic [2:0] LedHeartbeat     = 3'd1;
  localparam logic [2:0] LedWarning       = 3'd2;
  localparam logic [2:0] LedSteadyLow     = 3'd3;
  localparam logic [2:0] LedTriple        = 3'd4;
  localparam logic [2:0] LedDouble        = 3'd5;
  localparam logic [2:0] LedUnchanged     = 3'd6;

  // Configuration register indexes.
  localparam logic [2:0] CfgShutdownSoc     = 3'd0;
  localparam logic [2:0] CfgShutdownPrevSoc = 3'd1;
  localparam logic [2:0] CfgBlinkSoc        = 3'd2;
  localparam logic [2:0] CfgBlinkPrevSoc    = 3'd3;
  localparam logic [2:0] CfgWarnSoc         = 3'd4;
  localparam logic [2:0] CfgWarnPrevSoc     = 3'd5;
  localparam logic [2:0] CfgOvertempLimit   = 3'd6;

  // Configuration register reset values.
  localparam logic [6:0] RstShutdownSoc     = 7'd8;
  localparam logic [6:0] RstShutdownPrevSoc = 7'd10;
  localparam logic [6:0] RstBlinkSoc        = 7'd10;
  localparam logic [6:0] RstBlinkPrevSoc    = 7'd12;
  localparam logic [6:0] RstWarnSoc         = 7'd15;
  localparam logic [6:0] RstWarnPrevSoc     = 7'd17;
  localparam logic [3:0] RstOvertempLimit   = 4'd4;

  typedef struct packed {
    logic [6:0] shutdown_soc;
    logic [6:0] shutdown_prev_soc;
    logic [6:0] blink_soc;
    logic [6:0] blink_prev_soc;
    logic [6:0] warn_soc;
    logic [6:0] warn_prev_soc;
    logic [3:0] overtemp_limit;
  } cfg_t;

  typedef struct packed {
    logic       shutdown_request;
    logic [2:0] led_pattern;
    logic       display_blink;
    logic       charger_disable;
    logic       status_bad;
  } result_t;

endpackage

@@ rtl/core/bcmp_cfg.sv @@
`timescale 1ns / 1ps

module bcmp_cfg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [6:0]          cfg_data_i,
  output bcmp_pkg::cfg_t      cfg_o
);

  bcmp_pkg::cfg_t cfg_q, cfg_d;

  // Writes are always taken; an index past the last register is dropped.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        bcmp_pkg::CfgShutdownSoc:     cfg_d.shutdown_soc      = cfg_data_i;
        bcmp_pkg::CfgShutdownPrevSoc: cfg_d.shutdown_prev_soc = cfg_data_i;
        bcmp_pkg::CfgBlinkSoc:        cfg_d.blink_soc         = cfg_data_i;
        bcmp_pkg::CfgBlinkPrevSoc:    cfg_d.blink_prev_soc    = cfg_data_i;
        bcmp_pkg::CfgWarnSoc:         cfg_d.warn_soc          = cfg_data_i;
        bcmp_pkg::CfgWarnPrevSoc:     cfg_d.warn_prev_soc     = cfg_data_i;
        bcmp_pkg::CfgOvertempLimit:   cfg_d.overtemp_limit    = cfg_data_i[3:0];
        default:                      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.shutdown_soc      <= bcmp_pkg::RstShutdownSoc;
      cfg_q.shutdown_prev_soc <= bcmp_pkg::RstShutdownPrevSoc;
      cfg_q.blink_soc         <= bcmp_pkg::RstBlinkSoc;
      cfg_q.blink_prev_soc    <= bcmp_pkg::RstBlinkPrevSoc;
      cfg_q.warn_soc          <= bcmp_pkg::RstWarnSoc;
      cfg_q.warn_prev_soc     <= bcmp_pkg::RstWarnPrevSoc;
      cfg_q.overtemp_limit    <= bcmp_pkg::RstOvertempLimit;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/core/bcmp_eval.sv @@
`timescale 1ns / 1ps

module bcmp_eval (
  input  logic [15:0]         status_word_i,
  input  logic                status_nack_i,
  input  logic [15:0]         soc_value_i,
  input  logic [15:0]         prev_soc_i,
  input  logic [3:0]          count_i,
  input  bcmp_pkg::cfg_t      cfg_i,
  output bcmp_pkg::result_t   res_o,
  output logic [15:0]         prev_soc_o,
  output logic [3:0]          count_o
);

  logic       bad;
  logic       overtemp;
  logic       discharging;
  logic       full;
  logic [3:0] count_inc;
  logic       hit_shutdown;
  logic       hit_blink;
  logic       hit_warn;

  assign bad         = status_nack_i || (status_word_i == bcmp_pkg::StatusAllOnes);
  assign overtemp    = status_word_i[bcmp_pkg::BitOvertemp];
  assign discharging = status_word_i[bcmp_pkg::BitDischarging];
  assign full        = status_word_i[bcmp_pkg::BitFull];

  // Saturating over-temperature count.
  assign count_inc = (count_i < bcmp_pkg::CountMax) ? count_i + 4'd1 : count_i;

  // Threshold pairs, compared as plain unsigned values.
  assign hit_shutdown = (soc_value_i <= {9'd0, cfg_i.shutdown_soc}) &&
                        (prev_soc_i  <= {9'd0, cfg_i.shutdown_prev_soc});
  assign hit_blink    = (soc_value_i <= {9'd0, cfg_i.blink_soc}) &&
                        (prev_soc_i  <= {9'd0, cfg_i.blink_prev_soc});
  assign hit_warn     = (soc_value_i <= {9'd0, cfg_i.warn_soc}) &&
                        (prev_soc_i  <= {9'd0, cfg_i.warn_prev_soc});

  always_comb begin
    res_o.shutdown_request = 1'b0;
    res_o.led_pattern      = bcmp_pkg::LedSteadyErr;
    res_o.display_blink    = 1'b0;
    res_o.charger_disable  = 1'b0;
    res_o.status_bad       = bad;
    prev_soc_o             = prev_soc_i;
    count_o                = count_i;

    if (!bad) begin
      // Over-temperature tracking.
      if (overtemp) begin
        count_o = count_inc;
        if (count_inc >= cfg_i.overtemp_limit) begin
          res_o.shutdown_request = 1'b1;
        end
      end else begin
        count_o = 4'd0;
      end

      // Charge policy.
      if (discharging) begin
        if (hit_shutdown) begin
          res_o.shutdown_request = 1'b1;
          res_o.led_pattern      = bcmp_pkg::LedUnchanged;
        end else if (hit_blink) begin
          res_o.display_blink    = 1'b1;
          res_o.led_pattern      = bcmp_pkg::LedSteadyLow;
        end else if (hit_warn) begin
          res_o.led_pattern      = bcmp_pkg::LedWarning;
        end else begin
          res_o.led_pattern      = bcmp_pkg::LedHeartbeat;
        end
        prev_soc_o = soc_value_i;
      end else if (full) begin
        res_o.charger_disable = 1'b1;
        res_o.led_pattern     = bcmp_pkg::LedTriple;
      end else begin
        res_o.led_pattern     = bcmp_pkg::LedDouble;
      end
    end
  end

endmodule

@@ rtl/core/battery_charge_monitor_policy.sv @@
`timescale 1ns / 1ps

// Battery charge monitor policy. Each poll beat (status word, nack flag,
// charge) yields one result beat (shutdown request, LED pattern, display
// blink, charger disable, bad-read flag). The block takes one poll per
// cycle at full rate while results are taken. A poll is held in the input
// register, and the decision logic feeds the result register, which offers
// the result beat. While the result is held off, one more poll can wait in
// the input register before the poll side stalls. The stored charge and the
// over-temperature count update as a poll leaves the input register, so
// back-to-back polls see each other's state in order. Configuration writes
// are taken in any cycle and must only be issued while no poll is in flight.
module battery_charge_monitor_policy (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Poll stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] status_word, [31:16] soc_value
  input  logic [0:0]  s_axis_tuser,   // [0] status_nack
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [0] shutdown_request, [3:1] led_pattern,
                                      // [4] display_blink, [5] charger_disable,
                                      // [7:6] zero
  output logic [0:0]  m_axis_tuser,   // [0] status_bad
  // Configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [6:0]  cfg_data_i
);

  bcmp_pkg::cfg_t    cfg;
  bcmp_pkg::result_t res;
  bcmp_pkg::result_t res_q;

  logic        in_valid_q;
  logic [15:0] in_status_q;
  logic        in_nack_q;
  logic [15:0] in_soc_q;
  logic        out_valid_q;
  logic [15:0] prev_soc_q, prev_soc_d;
  logic [3:0]  count_q, count_d;
  logic        out_free;
  logic        advance;

  bcmp_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  bcmp_eval u_eval (
    .status_word_i (in_status_q),
    .status_nack_i (in_nack_q),
    .soc_value_i   (in_soc_q),
    .prev_soc_i    (prev_soc_q),
    .count_i       (count_q),
    .cfg_i         (cfg),
    .res_o         (res),
    .prev_soc_o    (prev_soc_d),
    .count_o       (count_d)
  );

  // Handshake: the input register moves on whenever the result slot is free.
  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_status_q <= s_axis_tdata[15:0];
      in_soc_q    <= s_axis_tdata[31:16];
      in_nack_q   <= s_axis_tuser[0];
    end
  end

  // Policy state, updated as each poll is evaluated.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_soc_q <= bcmp_pkg::SocReset;
      count_q    <= 4'd0;
    end else if (advance) begin
      prev_soc_q <= prev_soc_d;
      count_q    <= count_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, res_q.charger_disable, res_q.display_blink,
                          res_q.led_pattern, res_q.shutdown_request};
  assign m_axis_tuser  = res_q.status_bad;

  // A bad read leaves every action field clear.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[5:0] == 6'd0))
    else $error("bad read result carries an action");

  // Charger disable only comes with the full-charge pattern.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[5]) |->
      (m_axis_tdata[3:1] == bcmp_pkg::LedTriple && !m_axis_tdata[4]))
    else $error("charger disable without full pattern");

  // Display blink only comes with the low-charge steady pattern.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[4]) |->
      (m_axis_tdata[3:1] == bcmp_pkg::LedSteadyLow))
    else $error("display blink with wrong pattern");

  // A held poll stays in the input register until the result slot frees.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !out_free) |=> (in_valid_q && $stable(in_status_q)))
    else $error("stalled poll lost from input register");

endmodule

@@ verif/bcmp_checker.sv @@
`timescale 1ns / 1ps

// Watches the poll, result and register-write channels of the battery charge
// monitor. It keeps its own copy of the thresholds, the stored charge and the
// over-temperature count. It works out the result of every accepted poll beat
// and compares each result beat with the oldest expectation.
module bcmp_checker
  import bcmp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        poll_valid_i,
  input  logic        poll_ready_i,
  input  logic [31:0] poll_data_i,    // [15:0] status_word, [31:16] soc_value
  input  logic [0:0]  poll_user_i,    // [0] status_nack
  input  logic        res_valid_i,
  input  logic        res_ready_i,
  input  logic [7:0]  res_data_i,     // [0] shutdown, [3:1] led, [4] blink, [5] chg_dis
  input  logic [0:0]  res_user_i,     // [0] status_bad
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [6:0]  cfg_data_i,
  output int          mismatches_o,
  output int          outstanding_o,
  output int          results_seen_o
);

  cfg_t        thresholds;
  logic [15:0] last_soc;
  logic [3:0]  hot_count;
  result_t     pending_results[$];
  result_t     want;
  result_t     got;
  int          mismatches;
  int          results_seen;

  // Decide the outcome of one poll and advance the stored charge and count.
  function automatic result_t judge_poll(input logic [15:0] status, input logic nack,
                                         input logic [15:0] soc);
    result_t r;
    r = '0;
    r.led_pattern = LedSteadyErr;
    r.status_bad  = nack || (status == StatusAllOnes);
    if (!r.status_bad) begin
      if (status[BitOvertemp]) begin
        if (hot_count < CountMax) hot_count = hot_count + 4'd1;
        if (hot_count >= thresholds.overtemp_limit) r.shutdown_request = 1'b1;
      end else begin
        hot_count = '0;
      end

      if (status[BitDischarging]) begin
        if (soc <= thresholds.shutdown_soc && last_soc <= thresholds.shutdown_prev_soc) begin
          r.shutdown_request = 1'b1;
          r.led_pattern      = LedUnchanged;
        end else if (soc <= thresholds.blink_soc &&
                     last_soc <= thresholds.blink_prev_soc) begin
          r.display_blink = 1'b1;
          r.led_pattern   = LedSteadyLow;
        end else if (soc <= thresholds.warn_soc &&
                     last_soc <= thresholds.warn_prev_soc) begin
          r.led_pattern = LedWarning;
        end else begin
          r.led_pattern = LedHeartbeat;
        end
        last_soc = soc;
      end else if (status[BitFull]) begin
        r.charger_disable = 1'b1;
        r.led_pattern     = LedTriple;
      end else begin
        r.led_pattern = LedDouble;
      end
    end
    return r;
  endfunction

  task automatic compare_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
    if (exp_v != act_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresholds.shutdown_soc      = RstShutdownSoc;
      thresholds.shutdown_prev_soc = RstShutdownPrevSoc;
      thresholds.blink_soc         = RstBlinkSoc;
      thresholds.blink_prev_soc    = RstBlinkPrevSoc;
      thresholds.warn_soc          = RstWarnSoc;
      thresholds.warn_prev_soc     = RstWarnPrevSoc;
      thresholds.overtemp_limit    = RstOvertempLimit;
      last_soc     = SocReset;
      hot_count    = '0;
      mismatches   = 0;
      results_seen = 0;
      pending_results.delete();
    end else begin
      // Register writes must only be issued while no poll is in flight; the checker does not enforce it.
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgShutdownSoc:     thresholds.shutdown_soc      = cfg_data_i;
          CfgShutdownPrevSoc: thresholds.shutdown_prev_soc = cfg_data_i;
          CfgBlinkSoc:        thresholds.blink_soc         = cfg_data_i;
          CfgBlinkPrevSoc:    thresholds.blink_prev_soc    = cfg_data_i;
          CfgWarnSoc:         thresholds.warn_soc          = cfg_data_i;
          CfgWarnPrevSoc:     thresholds.warn_prev_soc     = cfg_data_i;
          CfgOvertempLimit:   thresholds.overtemp_limit    = cfg_data_i[3:0];
          default: ;
        endcase
      end

      // Compare a result beat against the oldest expectation.
      if (res_valid_i && res_ready_i) begin
        results_seen++;
        got.shutdown_request = res_data_i[0];
        got.led_pattern      = res_data_i[3:1];
        got.display_blink    = res_data_i[4];
        got.charger_disable  = res_data_i[5];
        got.status_bad       = res_user_i[0];
        if (pending_results.size() == 0) begin
          mismatches++;
          $display("%0t: result beat with no poll outstanding, expected none, actual %h/%h",
                   $time, res_data_i, res_user_i);
        end else begin
          want = pending_results.pop_front();
          compare_field("shutdown_request", want.shutdown_request, got.shutdown_request);
          compare_field("led_pattern", want.led_pattern, got.led_pattern);
          compare_field("display_blink", want.display_blink, got.display_blink);
          compare_field("charger_disable", want.charger_disable, got.charger_disable);
          compare_field("status_bad", want.status_bad, got.status_bad);
          compare_field("tdata padding", 0, res_data_i[7:6]);
        end
      end

      // Predict the result of an accepted poll beat.
      if (poll_valid_i && poll_ready_i) begin
        pending_results.push_back(judge_poll(poll_data_i[15:0], poll_user_i[0],
                                             poll_data_i[31:16]));
      end
    end
    mismatches_o   <= mismatches;
    outstanding_o  <= pending_results.size();
    results_seen_o <= results_seen;
  end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import bcmp_pkg::*;

  localparam int          CycleLimit = 200000;
  localparam int          HoldCycles = 300;
  localparam logic [2:0]  CfgUnused  = 3'd7;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        poll_valid = 1'b0;
  logic        poll_ready;
  logic [31:0] poll_data  = '0;
  logic [0:0]  poll_user  = '0;
  logic        res_valid;
  logic        res_ready  = 1'b0;
  logic [7:0]  res_data;
  logic [0:0]  res_user;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index  = '0;
  logic [6:0]  cfg_data   = '0;

  int mismatches;
  int outstanding;
  int results_seen;
  int cycles          = 0;
  int polls_sent      = 0;
  int settings_loaded = 0;
  int hot_left        = 0;
  int soc_walk        = 40;
  bit src_gaps        = 1'b1;
  bit sink_gaps       = 1'b1;
  bit hold_req        = 1'b0;

  always #5 clk = ~clk;

  battery_charge_monitor_policy DUT (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (poll_valid),
    .s_axis_tready (poll_ready),
    .s_axis_tdata  (poll_data),
    .s_axis_tuser  (poll_user),
    .m_axis_tvalid (res_valid),
    .m_axis_tready (res_ready),
    .m_axis_tdata  (res_data),
    .m_axis_tuser  (res_user),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  bcmp_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .poll_valid_i   (poll_valid),
    .poll_ready_i   (poll_ready),
    .poll_data_i    (poll_data),
    .poll_user_i    (poll_user),
    .res_valid_i    (res_valid),
    .res_ready_i    (res_ready),
    .res_data_i     (res_data),
    .res_user_i     (res_user),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .mismatches_o   (mismatches),
    .outstanding_o  (outstanding),
    .results_seen_o (results_seen)
  );

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Run exceeded %0d cycles with %0d results outstanding.", CycleLimit, outstanding);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result side: random back-pressure, plus one long hold-off on request.
  initial begin : sink_proc
    int n;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        res_ready <= 1'b0;
        for (n = 0; n < HoldCycles; n++) @(posedge clk);
        hold_req = 1'b0;
      end
      res_ready <= !sink_gaps || ($urandom_range(99) >= 29);
    end
  end

  // Offer one poll beat, with random gaps in front, and wait for acceptance.
  task automatic send_poll(input logic [15:0] status, input logic nack,
                           input logic [15:0] soc);
    while (src_gaps && $urandom_range(99) < 29) begin
      poll_valid <= 1'b0;
      @(posedge clk);
    end
    poll_valid <= 1'b1;
    poll_data  <= {soc, status};
    poll_user  <= nack;
    @(posedge clk);
    while (!poll_ready) @(posedge clk);
    polls_sent++;
  endtask

  // Stop offering polls, then wait until every expected result has come
  // back and the block is quiet.
  task automatic wait_idle();
    poll_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [6:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Write all seven registers, and optionally the unused index; junk goes into the unused upper limit bits.
  task automatic load_settings(input cfg_t c, input bit poke_unused);
    logic [2:0] junk;
    logic [6:0] stray;
    junk  = 3'($urandom_range(7));
    stray = 7'($urandom_range(127));
    wait_idle();
    write_reg(CfgShutdownSoc, c.shutdown_soc);
    write_reg(CfgShutdownPrevSoc, c.shutdown_prev_soc);
    write_reg(CfgBlinkSoc, c.blink_soc);
    write_reg(CfgBlinkPrevSoc, c.blink_prev_soc);
    write_reg(CfgWarnSoc, c.warn_soc);
    write_reg(CfgWarnPrevSoc, c.warn_prev_soc);
    write_reg(CfgOvertempLimit, {junk, c.overtemp_limit});
    if (poke_unused) write_reg(CfgUnused, stray);
    cfg_valid <= 1'b0;
    settings_loaded++;
  endtask

  // Thresholds mostly near the charge range the polls walk through.
  function automatic logic [6:0] pick_threshold();
    if ($urandom_range(99) < 80) return 7'($urandom_range(40));
    return 7'($urandom_range(127));
  endfunction

  function automatic cfg_t rand_settings();
    cfg_t c;
    c.shutdown_soc      = pick_threshold();
    c.shutdown_prev_soc = pick_threshold();
    c.blink_soc         = pick_threshold();
    c.blink_prev_soc    = pick_threshold();
    c.warn_soc          = pick_threshold();
    c.warn_prev_soc     = pick_threshold();
    c.overtemp_limit    = 4'($urandom_range(15));
    return c;
  endfunction

  // Mostly a battery draining step by step with over-temperature runs, mixed
  // with bad reads and charge values anywhere in the 16-bit range.
  task automatic send_random_poll();
    logic [15:0] status;
    logic        nack;
    logic [15:0] soc;
    int          pick;
    status = 16'($urandom_range(16'hffff));
    nack   = 1'b0;
    if (hot_left == 0 && $urandom_range(99) < 4) hot_left = $urandom_range(1, 20);
    status[BitOvertemp]    = (hot_left != 0) || ($urandom_range(99) < 5);
    status[BitDischarging] = ($urandom_range(99) < 70);
    if (hot_left != 0) hot_left--;

    pick = $urandom_range(99);
    if (pick < 50) begin
      soc_walk = soc_walk - $urandom_range(3);
      if (soc_walk < 0 || $urandom_range(99) < 3) soc_walk = $urandom_range(20, 60);
      soc = 16'(soc_walk);
    end else if (pick < 80) begin
      soc = 16'($urandom_range(40));
    end else if (pick < 90) begin
      soc = 16'($urandom_range(127));
    end else begin
      soc = 16'($urandom_range(16'hffff));
    end

    pick = $urandom_range(99);
    if (pick < 6) begin
      nack = 1'b1;
    end else if (pick < 9) begin
      status = StatusAllOnes;
      nack   = 1'($urandom_range(1));
    end
    send_poll(status, nack, soc);
  endtask

  // Directed polls under the reset thresholds: bad reads, each LED pattern,
  // the charge ladder down to shutdown, and counting over-temperature.
  task automatic run_directed();
    send_poll(16'h0000, 1'b1, 16'd5);
    send_poll(StatusAllOnes, 1'b0, 16'd0);
    send_poll(StatusAllOnes, 1'b1, 16'hffff);
    send_poll(16'h0020, 1'b0, 16'd0);
    send_poll(16'h0000, 1'b0, 16'd0);
    send_poll(16'h0040, 1'b0, 16'd16);
    send_poll(16'h0040, 1'b0, 16'd14);
    send_poll(16'h0040, 1'b0, 16'd9);
    send_poll(16'h0040, 1'b0, 16'd10);
    send_poll(16'h0040, 1'b0, 16'd8);
    send_poll(16'h0040, 1'b0, 16'd0);
    send_poll(16'h0060, 1'b0, 16'hffff);
    send_poll(16'h0040, 1'b0, 16'd0);
    send_poll(16'h1000, 1'b0, 16'd0);
    send_poll(16'h1040, 1'b0, 16'd5);
    send_poll(16'h1000, 1'b1, 16'd0);
    send_poll(16'h1020, 1'b0, 16'd0);
    send_poll(16'h1000, 1'b0, 16'd0);
    send_poll(16'hfffe, 1'b0, 16'd0);
    send_poll(16'h0000, 1'b0, 16'd0);
    send_poll(16'h1000, 1'b0, 16'd0);
    send_poll(16'h8f9f, 1'b0, 16'h8000);
  endtask

  initial begin : stimulus
    cfg_t c;
    int   ph;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();

    // Register settings: the extremes first, then random ones.
    for (ph = 0; ph < 9; ph++) begin
      case (ph)
        0:       c = '0;
        1:       c = '{7'd127, 7'd127, 7'd127, 7'd127, 7'd127, 7'd127, 4'd15};
        2:       c = '{7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 4'd1};
        default: c = rand_settings();
      endcase
      load_settings(c, ph == 3);
      src_gaps  = (ph != 4) && (ph != 6);
      sink_gaps = (ph != 4);
      if (ph == 6) hold_req = 1'b1;
      repeat (200) send_random_poll();
    end

    wait_idle();
    repeat (8) @(posedge clk);
    $display("Run covered %0d polls under %0d register settings; %0d results checked.",
             polls_sent, settings_loaded + 1, results_seen);
    $display("It included a %0d-cycle result hold-off and a stretch with no gaps.",
             HoldCycles);
    if (mismatches == 0 && outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
